// ===== rtl/canmr_pkg.sv =====
// Shared types and constants of the CAN multi-frame reassembler.
`default_nettype none

package canmr_pkg;

   localparam int NUM_SLOTS     = 8;
   localparam int MAX_MSG_BYTES = 64;
   localparam int FRAME_BYTES   = 8;

   localparam int SLOT_W     = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
   localparam int LANE_W     = $clog2(FRAME_BYTES);
   localparam int LEN_W      = 7;
   localparam int POS_W      = 6;
   localparam int CNT_W      = 4;
   localparam int ROWS       = (MAX_MSG_BYTES + FRAME_BYTES - 1) / FRAME_BYTES;
   localparam int BANK_DEPTH = NUM_SLOTS * ROWS;
   localparam int BANK_AW    = (BANK_DEPTH > 1) ? $clog2(BANK_DEPTH) : 1;

   typedef enum logic [1:0] {
      SEG_FIRST  = 2'd0,
      SEG_MIDDLE = 2'd1,
      SEG_LAST   = 2'd2,
      SEG_NONE   = 2'd3
   } seg_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_LOOKUP,
      ST_WRITE,
      ST_READ,
      ST_SHOW
   } state_type;

   typedef struct packed {
      logic [3:0]       sender;
      logic [7:0]       msg_type;
      logic [1:0]       segment_flag;
      logic [CNT_W-1:0] byte_count;
      logic [7:0]       data_byte0;
      logic [7:0]       data_byte1;
      logic [7:0]       data_byte2;
      logic [7:0]       data_byte3;
      logic [7:0]       data_byte4;
      logic [7:0]       data_byte5;
      logic [7:0]       data_byte6;
      logic [7:0]       data_byte7;
   } req_payload_type;

   typedef struct packed {
      logic [3:0]       out_sender;
      logic [7:0]       out_type;
      logic [LEN_W-1:0] total_length;
      logic [POS_W-1:0] byte_pos;
      logic [7:0]       byte_value;
      logic             truncated;
      logic             last_byte;
   } rsp_payload_type;

   typedef struct packed {
      logic             we;
      logic             alloc;
      logic [3:0]       sender;
      logic [7:0]       msg_type;
      logic [LEN_W-1:0] length;
      logic             overflow;
   } slot_upd_type;

   typedef struct packed {
      logic             valid;
      logic             match;
      logic [3:0]       sender;
      logic [7:0]       msg_type;
      logic [LEN_W-1:0] length;
      logic             overflow;
   } slot_state_type;

   typedef struct packed {
      logic              hit;
      logic [SLOT_W-1:0] hit_idx;
      logic              free;
      logic [SLOT_W-1:0] free_idx;
   } lookup_type;

endpackage

`default_nettype wire

// ===== rtl/can_multiframe_reassembler.sv =====
// Top level of the CAN multi-frame reassembler.
//
//   channel  direction  handshake             beat
//   req_     in         req_valid/req_ready   one decoded frame
//   rsp_     out        rsp_valid/rsp_ready   one byte of a completed message
//
// A frame is accepted, looked up across all entry lanes, and then written as up to
// eight bytes into eight byte banks at once. A frame that finds no entry, or
// carries the ignored flag, ends after the lookup. A last frame then emits its
// message byte by byte: each byte is a registered read of the byte banks, then a
// beat held until rsp_ready takes it. No new frame is taken until then.
// Reset clears the valid bit of every entry; the byte banks need no clearing.
`default_nettype none

module can_multiframe_reassembler (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        req_valid,
   output logic                             req_ready,
   input  wire canmr_pkg::req_payload_type  req_payload,
   output logic                             rsp_valid,
   input  wire logic                        rsp_ready,
   output canmr_pkg::rsp_payload_type       rsp_payload
);
   import canmr_pkg::*;

   state_type         state_ff, state_in;
   req_payload_type   item_ff;
   logic [SLOT_W-1:0] slot_ff, slot_in;
   logic              alloc_ff, alloc_in;
   logic [POS_W-1:0]  pos_ff, pos_in;

   slot_state_type    lane_status [NUM_SLOTS];
   slot_upd_type      lane_upd    [NUM_SLOTS];
   logic [NUM_SLOTS-1:0] match_vec, valid_vec;
   lookup_type        lookup;
   logic              lookup_act;

   logic [7:0]        frame_bytes [FRAME_BYTES];
   logic [CNT_W-1:0]  cnt_eff;
   logic              is_first;
   slot_state_type    sel;
   logic [LEN_W-1:0]  base_len;
   logic [LEN_W:0]    sum_len;
   logic [LEN_W-1:0]  new_len;
   logic              new_ovf;
   logic              write_en, read_en, last_now;

   logic [FRAME_BYTES-1:0] bank_we;
   logic [BANK_AW-1:0]     bank_waddr [FRAME_BYTES];
   logic [7:0]             bank_wdata [FRAME_BYTES];
   logic [BANK_AW-1:0]     bank_raddr;
   logic [7:0]             bank_rdata [FRAME_BYTES];

   assign frame_bytes[0] = item_ff.data_byte0;
   assign frame_bytes[1] = item_ff.data_byte1;
   assign frame_bytes[2] = item_ff.data_byte2;
   assign frame_bytes[3] = item_ff.data_byte3;
   assign frame_bytes[4] = item_ff.data_byte4;
   assign frame_bytes[5] = item_ff.data_byte5;
   assign frame_bytes[6] = item_ff.data_byte6;
   assign frame_bytes[7] = item_ff.data_byte7;

   assign cnt_eff  = (item_ff.byte_count > CNT_W'(FRAME_BYTES)) ? CNT_W'(FRAME_BYTES)
                                                                : item_ff.byte_count;
   assign is_first = (item_ff.segment_flag == SEG_FIRST);

   for (genvar s = 0; s < NUM_SLOTS; s++) begin : g_slot
      always_comb begin
         lane_upd[s].we       = write_en && (slot_ff == SLOT_W'(s));
         lane_upd[s].alloc    = alloc_ff;
         lane_upd[s].sender   = item_ff.sender;
         lane_upd[s].msg_type = item_ff.msg_type;
         lane_upd[s].length   = new_len;
         lane_upd[s].overflow = new_ovf;
      end

      canmr_slot_lane u_lane (
         .clock      (clock),
         .reset      (reset),
         .key_sender (item_ff.sender),
         .key_type   (item_ff.msg_type),
         .upd        (lane_upd[s]),
         .status     (lane_status[s])
      );

      assign match_vec[s] = lane_status[s].match;
      assign valid_vec[s] = lane_status[s].valid;
   end

   canmr_slot_merge u_merge (
      .match  (match_vec),
      .valid  (valid_vec),
      .result (lookup)
   );

   always_comb begin
      lookup_act = 1'b0;
      slot_in    = slot_ff;
      alloc_in   = alloc_ff;
      unique case (item_ff.segment_flag)
         SEG_FIRST: begin
            lookup_act = lookup.hit || lookup.free;
            slot_in    = lookup.hit ? lookup.hit_idx : lookup.free_idx;
            alloc_in   = !lookup.hit;
         end
         SEG_MIDDLE, SEG_LAST: begin
            lookup_act = lookup.hit;
            slot_in    = lookup.hit_idx;
            alloc_in   = 1'b0;
         end
         default: begin
            lookup_act = 1'b0;
         end
      endcase
      if (state_ff != ST_LOOKUP) begin
         slot_in  = slot_ff;
         alloc_in = alloc_ff;
      end
   end

   assign sel      = lane_status[slot_ff];
   assign base_len = is_first ? '0 : sel.length;
   assign sum_len  = {1'b0, base_len} + (LEN_W + 1)'(cnt_eff);

   always_comb begin
      if (sum_len > (LEN_W + 1)'(MAX_MSG_BYTES)) begin
         new_len = LEN_W'(MAX_MSG_BYTES);
         new_ovf = 1'b1;
      end else begin
         new_len = sum_len[LEN_W-1:0];
         new_ovf = !is_first && sel.overflow;
      end
   end

   assign bank_raddr = BANK_AW'(slot_ff * ROWS + (pos_ff >> LANE_W));

   for (genvar b = 0; b < FRAME_BYTES; b++) begin : g_bank
      logic [LANE_W-1:0] offs;
      logic [LEN_W-1:0]  bpos;

      assign offs = LANE_W'(b) - base_len[LANE_W-1:0];
      assign bpos = base_len + LEN_W'(offs);
      assign bank_we[b]    = write_en && ({1'b0, offs} < cnt_eff)
                             && (bpos < LEN_W'(MAX_MSG_BYTES));
      assign bank_waddr[b] = BANK_AW'(slot_ff * ROWS + (bpos >> LANE_W));
      assign bank_wdata[b] = frame_bytes[offs];

      canmr_bank u_bank (
         .clock (clock),
         .we    (bank_we[b]),
         .waddr (bank_waddr[b]),
         .wdata (bank_wdata[b]),
         .re    (read_en),
         .raddr (bank_raddr),
         .rdata (bank_rdata[b])
      );
   end

   assign last_now = (sel.length == '0) || ((LEN_W'(pos_ff) + LEN_W'(1)) == sel.length);

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               state_in = ST_LOOKUP;
            end
         end
         ST_LOOKUP: begin
            state_in = lookup_act ? ST_WRITE : ST_IDLE;
         end
         ST_WRITE: begin
            state_in = (item_ff.segment_flag == SEG_LAST) ? ST_READ : ST_IDLE;
         end
         ST_READ: begin
            state_in = ST_SHOW;
         end
         ST_SHOW: begin
            if (rsp_ready) begin
               state_in = last_now ? ST_IDLE : ST_READ;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      req_ready = (state_ff == ST_IDLE);
      rsp_valid = (state_ff == ST_SHOW);
      write_en  = (state_ff == ST_WRITE);
      read_en   = (state_ff == ST_READ);
      pos_in    = pos_ff;
      if (state_ff == ST_WRITE) begin
         pos_in = '0;
      end else if ((state_ff == ST_SHOW) && rsp_ready && !last_now) begin
         pos_in = pos_ff + POS_W'(1);
      end
   end

   always_comb begin
      rsp_payload.out_sender   = sel.sender;
      rsp_payload.out_type     = sel.msg_type;
      rsp_payload.total_length = sel.length;
      rsp_payload.byte_pos     = pos_ff;
      rsp_payload.byte_value   = (sel.length == '0) ? 8'd0 : bank_rdata[pos_ff[LANE_W-1:0]];
      rsp_payload.truncated    = sel.overflow;
      rsp_payload.last_byte    = last_now;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         item_ff <= req_payload;
      end
      slot_ff  <= slot_in;
      alloc_ff <= alloc_in;
      pos_ff   <= pos_in;
   end

endmodule

`default_nettype wire

// ===== rtl/canmr_slot_lane.sv =====
// One table entry: key, length and overflow of a partial message, with key compare.
`default_nettype none

module canmr_slot_lane (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic [3:0]              key_sender,
   input  wire logic [7:0]              key_type,
   input  wire canmr_pkg::slot_upd_type upd,
   output canmr_pkg::slot_state_type    status
);
   import canmr_pkg::*;

   logic             valid_ff;
   logic             valid_in;
   logic [3:0]       sender_ff;
   logic [7:0]       type_ff;
   logic [LEN_W-1:0] length_ff;
   logic             overflow_ff;

   assign valid_in = valid_ff | (upd.we & upd.alloc);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (upd.we) begin
         length_ff   <= upd.length;
         overflow_ff <= upd.overflow;
         if (upd.alloc) begin
            sender_ff <= upd.sender;
            type_ff   <= upd.msg_type;
         end
      end
   end

   always_comb begin
      status.valid    = valid_ff;
      status.match    = valid_ff && (sender_ff == key_sender) && (type_ff == key_type);
      status.sender   = sender_ff;
      status.msg_type = type_ff;
      status.length   = length_ff;
      status.overflow = overflow_ff;
   end

endmodule

`default_nettype wire

// ===== rtl/canmr_slot_merge.sv =====
// Merges the per-entry compares into the matching entry and the lowest free entry.
`default_nettype none

module canmr_slot_merge (
   input  wire logic [canmr_pkg::NUM_SLOTS-1:0] match,
   input  wire logic [canmr_pkg::NUM_SLOTS-1:0] valid,
   output canmr_pkg::lookup_type                result
);
   import canmr_pkg::*;

   always_comb begin
      result = '0;
      for (int s = NUM_SLOTS - 1; s >= 0; s--) begin
         if (match[s]) begin
            result.hit     = 1'b1;
            result.hit_idx = SLOT_W'(s);
         end
         if (!valid[s]) begin
            result.free     = 1'b1;
            result.free_idx = SLOT_W'(s);
         end
      end
   end

endmodule

`default_nettype wire

// ===== rtl/canmr_bank.sv =====
// One byte bank of the message buffer, one write and one registered read port.
`default_nettype none

module canmr_bank (
   input  wire logic                          clock,
   input  wire logic                          we,
   input  wire logic [canmr_pkg::BANK_AW-1:0] waddr,
   input  wire logic [7:0]                    wdata,
   input  wire logic                          re,
   input  wire logic [canmr_pkg::BANK_AW-1:0] raddr,
   output logic [7:0]                         rdata
);
   import canmr_pkg::*;

   logic [7:0] mem [BANK_DEPTH];

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (re) begin
         rdata <= mem[raddr];
      end
   end

endmodule

`default_nettype wire

// ===== sim/can_multiframe_reassembler_tb.sv =====
// Self-checking testbench for the CAN multi-frame reassembler.
`timescale 1ns / 1ps

module can_multiframe_reassembler_tb;
   import canmr_pkg::*;

   localparam int CYCLE_LIMIT  = 400000;
   localparam int HOLD_CYCLES  = 400;
   localparam int REPORT_LIMIT = 10;

   class reassembly_scoreboard;
      bit              entry_live [NUM_SLOTS];
      logic [3:0]      entry_sender [NUM_SLOTS];
      logic [7:0]      entry_type [NUM_SLOTS];
      int              entry_len [NUM_SLOTS];
      bit              entry_ovf [NUM_SLOTS];
      logic [7:0]      entry_data [NUM_SLOTS][MAX_MSG_BYTES];
      rsp_payload_type message_bytes [$];
      int              faults;

      function new();
         faults = 0;
         foreach (entry_live[e]) entry_live[e] = 1'b0;
      endfunction

      function void append_bytes(int e, req_payload_type f);
         logic [7:0] lane [FRAME_BYTES];
         int         cnt;
         int         i;
         lane = '{f.data_byte0, f.data_byte1, f.data_byte2, f.data_byte3,
                  f.data_byte4, f.data_byte5, f.data_byte6, f.data_byte7};
         cnt = (f.byte_count > FRAME_BYTES) ? FRAME_BYTES : int'(f.byte_count);
         for (i = 0; i < cnt; i++) begin
            if (entry_len[e] < MAX_MSG_BYTES) begin
               entry_data[e][entry_len[e]] = lane[i];
               entry_len[e]++;
            end else begin
               entry_ovf[e] = 1'b1;
            end
         end
      endfunction

      function void push_byte(int e, int pos, logic [7:0] val, bit last);
         rsp_payload_type r;
         r.out_sender   = entry_sender[e];
         r.out_type     = entry_type[e];
         r.total_length = LEN_W'(entry_len[e]);
         r.byte_pos     = POS_W'(pos);
         r.byte_value   = val;
         r.truncated    = entry_ovf[e];
         r.last_byte    = last;
         message_bytes.insert(message_bytes.size(), r);
      endfunction

      function void note_frame(req_payload_type f);
         int e;
         int hit;
         int pos;
         hit = -1;
         for (e = 0; e < NUM_SLOTS; e++) begin
            if (hit < 0 && entry_live[e] && entry_sender[e] == f.sender &&
                entry_type[e] == f.msg_type) hit = e;
         end
         case (f.segment_flag)
            SEG_FIRST: begin
               if (hit < 0) begin
                  for (e = 0; e < NUM_SLOTS; e++) begin
                     if (hit < 0 && !entry_live[e]) hit = e;
                  end
                  if (hit >= 0) begin
                     entry_live[hit]   = 1'b1;
                     entry_sender[hit] = f.sender;
                     entry_type[hit]   = f.msg_type;
                  end
               end
               if (hit >= 0) begin
                  entry_len[hit] = 0;
                  entry_ovf[hit] = 1'b0;
                  append_bytes(hit, f);
               end
            end
            SEG_MIDDLE: begin
               if (hit >= 0) append_bytes(hit, f);
            end
            SEG_LAST: begin
               if (hit >= 0) begin
                  append_bytes(hit, f);
                  if (entry_len[hit] == 0) begin
                     push_byte(hit, 0, 8'h00, 1'b1);
                  end else begin
                     for (pos = 0; pos < entry_len[hit]; pos++)
                        push_byte(hit, pos, entry_data[hit][pos], pos == entry_len[hit] - 1);
                  end
               end
            end
            default: begin
            end
         endcase
      endfunction

      function void log_fault(string what, rsp_payload_type want, rsp_payload_type got);
         faults++;
         if (faults <= REPORT_LIMIT) begin
            $display("%s: expected sender %0d type %0h len %0d pos %0d byte %0h trunc %0b last %0b",
                     what, want.out_sender, want.out_type, want.total_length, want.byte_pos,
                     want.byte_value, want.truncated, want.last_byte);
            $display("   got sender %0d type %0h len %0d pos %0d byte %0h trunc %0b last %0b",
                     got.out_sender, got.out_type, got.total_length, got.byte_pos,
                     got.byte_value, got.truncated, got.last_byte);
         end
      endfunction

      function void check_beat(rsp_payload_type got);
         rsp_payload_type want;
         if (message_bytes.size() == 0) begin
            log_fault("beat with no message byte pending", '0, got);
         end else begin
            want = message_bytes.pop_front();
            if (got.out_sender !== want.out_sender || got.out_type !== want.out_type ||
                got.total_length !== want.total_length || got.byte_pos !== want.byte_pos ||
                got.byte_value !== want.byte_value || got.truncated !== want.truncated ||
                got.last_byte !== want.last_byte)
               log_fault("message byte mismatch", want, got);
         end
      endfunction
   endclass

   logic            clock = 1'b0;
   logic            reset = 1'b1;
   logic            req_valid = 1'b0;
   logic            req_ready;
   req_payload_type req_payload = '0;
   logic            rsp_valid;
   logic            rsp_ready = 1'b0;
   rsp_payload_type rsp_payload;

   int send_idle_pct = 0;
   int stall_pct = 0;
   int hold_req = 0;
   int hold_served = 0;
   int hold_left = 0;
   int cycles = 0;

   logic [3:0] pool_sender [NUM_SLOTS] = '{4'd0, 4'd15, 4'd5, 4'd10, 4'd3, 4'd12, 4'd6, 4'd9};
   logic [7:0] pool_type [NUM_SLOTS] = '{8'h00, 8'hFF, 8'hA5, 8'h5A, 8'h0F, 8'hF0, 8'h33, 8'hCC};

   reassembly_scoreboard board;

   always #6 clock = ~clock;

   can_multiframe_reassembler dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload)
   );

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) board.check_beat(rsp_payload);
   end

   always @(negedge clock) begin
      if (hold_left > 0) begin
         rsp_ready <= 1'b0;
         hold_left <= hold_left - 1;
      end else if (hold_served != hold_req) begin
         hold_served <= hold_req;
         hold_left   <= HOLD_CYCLES;
         rsp_ready   <= 1'b0;
      end else begin
         rsp_ready <= ($urandom_range(99) >= stall_pct);
      end
   end

   function automatic req_payload_type build_frame(logic [3:0] s, logic [7:0] t,
                                                   seg_type flag, logic [3:0] cnt,
                                                   logic [63:0] data);
      req_payload_type f;
      f = {s, t, flag, cnt, data};
      return f;
   endfunction

   function automatic logic [3:0] random_count();
      if ($urandom_range(7) == 0) return 4'($urandom_range(15, 9));
      return 4'($urandom_range(8));
   endfunction

   task automatic send_frame(req_payload_type f);
      @(negedge clock);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid   <= 1'b1;
      req_payload <= f;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      board.note_frame(f);
   endtask

   task automatic run_random(int n_items, int idle, int stall);
      int         sent;
      int         k;
      int         middles;
      int         m;
      logic [3:0] s;
      logic [7:0] t;
      seg_type    flag;
      send_idle_pct = idle;
      stall_pct     = stall;
      sent          = 0;
      while (sent < n_items) begin
         k = $urandom_range(NUM_SLOTS - 1);
         if ($urandom_range(9) == 0) begin
            s = 4'($urandom);
            t = 8'($urandom);
         end else begin
            s = pool_sender[k];
            t = pool_type[k];
         end
         if ($urandom_range(4) != 0) begin
            middles = ($urandom_range(9) == 0) ? $urandom_range(9, 6) : $urandom_range(3);
            send_frame(build_frame(s, t, SEG_FIRST, random_count(), {$urandom, $urandom}));
            for (m = 0; m < middles; m++)
               send_frame(build_frame(s, t, SEG_MIDDLE, random_count(), {$urandom, $urandom}));
            send_frame(build_frame(s, t, SEG_LAST, random_count(), {$urandom, $urandom}));
            sent += middles + 2;
         end else begin
            flag = seg_type'($urandom_range(3));
            send_frame(build_frame(s, t, flag, random_count(), {$urandom, $urandom}));
            sent++;
         end
      end
   endtask

   initial begin
      while (cycles < CYCLE_LIMIT) begin
         @(posedge clock);
         cycles++;
      end
      $display("[FAIL] regression broken");
      $finish;
   end

   initial begin
      int i;
      board = new();
      repeat (3) @(posedge clock);
      @(negedge clock) reset <= 1'b0;

      send_frame(build_frame(pool_sender[0], pool_type[0], SEG_NONE, 4'd8,
                             64'h0123_4567_89AB_CDEF));
      send_frame(build_frame(pool_sender[0], pool_type[0], SEG_MIDDLE, 4'd8,
                             64'hFFFF_FFFF_FFFF_FFFF));
      send_frame(build_frame(pool_sender[1], pool_type[1], SEG_LAST, 4'd8,
                             64'h0000_0000_0000_0000));
      send_frame(build_frame(pool_sender[0], pool_type[0], SEG_FIRST, 4'd0,
                             64'hFFFF_FFFF_FFFF_FFFF));
      send_frame(build_frame(pool_sender[0], pool_type[0], SEG_LAST, 4'd0,
                             64'hFFFF_FFFF_FFFF_FFFF));

      send_frame(build_frame(pool_sender[1], pool_type[1], SEG_FIRST, 4'd8,
                             64'hFFFF_FFFF_FFFF_FFFF));
      for (i = 0; i < 8; i++)
         send_frame(build_frame(pool_sender[1], pool_type[1], SEG_MIDDLE,
                                (i == 3) ? 4'd15 : 4'd8, {$urandom, $urandom}));
      send_frame(build_frame(pool_sender[1], pool_type[1], SEG_LAST, 4'd3,
                             64'h0000_0000_0000_0000));

      send_frame(build_frame(pool_sender[2], pool_type[2], SEG_FIRST, 4'd15,
                             64'h0123_4567_89AB_CDEF));
      send_frame(build_frame(pool_sender[2], pool_type[2], SEG_FIRST, 4'd5,
                             64'hFEDC_BA98_7654_3210));
      send_frame(build_frame(pool_sender[2], pool_type[2], SEG_LAST, 4'd2,
                             64'h5A5A_A5A5_0F0F_F0F0));

      send_frame(build_frame(pool_sender[3], pool_type[3], SEG_FIRST, 4'd4,
                             {$urandom, $urandom}));
      for (i = 4; i < NUM_SLOTS; i++)
         send_frame(build_frame(pool_sender[i], pool_type[i], SEG_FIRST, 4'd1,
                                {$urandom, $urandom}));

      // The table is full now, so this key never gets an entry.
      send_frame(build_frame(4'd7, 8'h81, SEG_FIRST, 4'd8, {$urandom, $urandom}));
      send_frame(build_frame(4'd7, 8'h81, SEG_LAST, 4'd8, {$urandom, $urandom}));

      hold_req = hold_req + 1;
      run_random(28, 0, 0);
      run_random(24, 68, 0);
      run_random(28, 0, 68);
      run_random(25, 13, 13);

      @(negedge clock) req_valid <= 1'b0;
      while (board.message_bytes.size() != 0) @(posedge clock);
      repeat (40) @(posedge clock);

      if (board.faults == 0 && board.message_bytes.size() == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule

// ===== files.f =====
rtl/canmr_pkg.sv
rtl/canmr_slot_lane.sv
rtl/canmr_slot_merge.sv
rtl/canmr_bank.sv
rtl/can_multiframe_reassembler.sv
sim/can_multiframe_reassembler_tb.sv
